[rtl/cnd_pkg.sv]
// ----------------------------------------------------------------------------
// cnd_pkg
// shared constants, types and constellation table functions for the demapper
// ----------------------------------------------------------------------------
package cnd_pkg;

    localparam int SW        = 16;           // sample width
    localparam int CW        = 16;           // rom coordinate width
    localparam int IW        = 10;           // point index width
    localparam int TAB_TOTAL = 348;
    localparam int TAB_AW    = 9;

    localparam logic [2:0] MOD_QPSK    = 3'd0;
    localparam logic [2:0] MOD_8PSK    = 3'd1;
    localparam logic [2:0] MOD_16QAM   = 3'd2;
    localparam logic [2:0] MOD_64QAM   = 3'd3;
    localparam logic [2:0] MOD_256QAM  = 3'd4;
    localparam logic [2:0] MOD_1024QAM = 3'd5;

    localparam logic [0:0] REG_MODULATION = 1'd0;
    localparam logic [0:0] REG_PROFILE    = 1'd1;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [IW-1:0] symbol;
        logic [31:0]   nearest;
        logic [31:0]   next;
    } t_search_res;

    // millionths to q12, round half away from zero
    function automatic t_coord to_q12(input int m);
        longint mag;
        longint r;
        mag = (m < 0) ? -longint'(m) : longint'(m);
        r   = (mag * 4096 + 500000) / 1000000;
        return (m < 0) ? t_coord'(-r) : t_coord'(r);
    endfunction

    function automatic int base_x(input int k);
        int t[92];
        t = '{1000000, 0, -1000000, 0,
              1000000, 707107, 0, -707107, -1000000, -707107, 0, 707107,
              866025, 500000, 1000000, 258819, -500000, 0, -866025, -258819,
              500000, 0, 866025, 258819, -866025, -500000, -1000000, -258819,
              1000000, 822878, 821137, 932897, 0, 822878, 821137, 932897,
              568218, 588429, 588429, 588429, 568218, 588429, 588429, 588429,
              152996, 117686, 117686, 117686, 152996, 117686, 117686, 117686,
              360142, 353057, 353057, 353057, 360142, 353057, 353057, 353057,
              0, -822878, -821137, -932897, -1000000, -822878, -821137, -932897,
              -568218, -588429, -588429, -588429, -568218, -588429, -588429, -588429,
              -152996, -117686, -117686, -117686, -152996, -117686, -117686, -117686,
              -360142, -353057, -353057, -353057, -360142, -353057, -353057, -353057};
        return t[k];
    endfunction

    function automatic int base_y(input int k);
        int t[92];
        t = '{0, 1000000, 0, -1000000,
              0, 707107, 1000000, 707107, 0, -707107, -1000000, -707107,
              500000, 866025, 0, 258819, 866025, 1000000, 500000, 258819,
              -866025, -1000000, -500000, -258819, -500000, -866025, 0, -258819,
              0, 568218, 152996, 360142, -1000000, -568218, -152996, -360142,
              822878, 588429, 117686, 353057, -822878, -588429, -117686, -353057,
              821137, 588429, 117686, 353057, -821137, -588429, -117686, -353057,
              932897, 588429, 117686, 353057, -932897, -588429, -117686, -353057,
              1000000, 568218, 152996, 360142, 0, -568218, -152996, -360142,
              822878, 588429, 117686, 353057, -822878, -588429, -117686, -353057,
              821137, 588429, 117686, 353057, -821137, -588429, -117686, -353057,
              932897, 588429, 117686, 353057, -932897, -588429, -117686, -353057};
        return t[k];
    endfunction

    // tabled profile point k in millionths, x when sel_y is 0
    function automatic int tab_milli(input int k, input bit sel_y);
        int x0[16];
        int y0[16];
        int x1[16];
        int y1[16];
        int yin[16];
        int yedge[16];
        int cx[4];
        int r;
        int sg;
        int grp;
        int i;
        int x;
        int y;
        x0 = '{959366, 959366, 846499, 959366, 846499, 846499, 846499, 846499,
               959366, 959366, 846499, 959366, 846499, 846499, 846499, 846499};
        y0 = '{56433, 169300, 507899, 282166, 56433, 169300, 395033, 282166,
               -56433, -169300, -507899, -282166, -56433, -169300, -395033, -282166};
        x1 = '{169300, 56433, 733632, 733632, 733632, 733632, 733632, 733632,
               169300, 56433, 733632, 733632, 733632, 733632, 733632, 733632};
        y1 = '{959366, 998304, 507899, 620766, 56433, 169300, 395033, 282166,
               -959366, -998304, -507899, -620766, -56433, -169300, -395033, -282166};
        yin = '{846499, 733632, 507899, 620766, 56433, 169300, 395033, 282166,
                -846499, -733632, -507899, -620766, -56433, -169300, -395033, -282166};
        yedge = '{959366, 733632, 507899, 620766, 56433, 169300, 395033, 282166,
                  -959366, -733632, -507899, -620766, -56433, -169300, -395033, -282166};
        cx = '{56433, 169300, 395033, 282166};
        if (k < 92) begin
            return sel_y ? base_y(k) : base_x(k);
        end
        r   = k - 92;
        sg  = (r >= 128) ? -1 : 1;
        r   = r % 128;
        grp = r / 16;
        i   = r % 16;
        case (grp)
            0: begin x = x0[i]; y = y0[i]; end
            1: begin x = x1[i]; y = y1[i]; end
            2: begin x = 507899; y = yin[i]; end
            3: begin x = (i == 0 || i == 8) ? 282166 : 620766; y = yedge[i]; end
            default: begin x = cx[grp-4]; y = yin[i]; end
        endcase
        return sel_y ? y : sg * x;
    endfunction

    function automatic t_coord tab_coord(input logic [TAB_AW-1:0] a, input bit sel_y);
        if (int'(a) >= TAB_TOTAL) begin
            return t_coord'(0);
        end
        return to_q12(tab_milli(int'(a), sel_y));
    endfunction

    // square qam axis level for side = 2**sb, axis index g (gray)
    function automatic t_coord sq_coord(input int sb, input logic [4:0] g);
        int       side;
        int       b;
        int       a;
        int       s2;
        longint   mag;
        longint   lim;
        longint   n;
        logic [4:0] v;
        side = 1 << sb;
        v = g;
        for (int s = 1; s < 5; s++) begin
            v = v ^ (g >> s);
        end
        b = int'(v);
        a = 2 * b + 1 - side;
        s2 = (sb == 2) ? 10 : (sb == 3) ? 42 : (sb == 4) ? 170 : 682;
        mag = (a < 0) ? -a : a;
        lim = 4 * mag * mag * (longint'(1) << 24);
        n = 0;
        while ((2 * n + 1) * (2 * n + 1) * s2 <= lim) begin
            n++;
        end
        return (a < 0) ? t_coord'(-n) : t_coord'(n);
    endfunction

endpackage

[rtl/cnd_rom.sv]
// ----------------------------------------------------------------------------
// cnd_rom
// constellation point memory, one registered read per cycle
// ----------------------------------------------------------------------------
module cnd_rom (
    input  logic                   i_clk,
    input  logic                   i_square,
    input  logic [1:0]             i_row,
    input  logic [2:0]             i_sb,
    input  logic [cnd_pkg::IW-1:0] i_k,
    input  logic [cnd_pkg::TAB_AW-1:0] i_tab_addr,
    output cnd_pkg::t_coord        o_px,
    output cnd_pkg::t_coord        o_py
);
    import cnd_pkg::*;

    t_coord mem_tx [TAB_TOTAL];
    t_coord mem_ty [TAB_TOTAL];
    t_coord mem_sq [128];

    // contents are fixed at elaboration
    always_comb begin
        for (int j = 0; j < TAB_TOTAL; j++) begin
            mem_tx[j] = tab_coord(TAB_AW'(j), 1'b0);
            mem_ty[j] = tab_coord(TAB_AW'(j), 1'b1);
        end
        for (int j = 0; j < 128; j++) begin
            mem_sq[j] = sq_coord(j / 32 + 2, 5'(j % 32));
        end
    end

    logic [4:0] w_gi;
    logic [4:0] w_gq;

    always_comb begin
        w_gi = 5'(i_k >> i_sb);
        w_gq = 5'(i_k & ((IW'(1) << i_sb) - IW'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (i_square) begin
            o_px <= mem_sq[{i_row, w_gi}];
            o_py <= mem_sq[{i_row, w_gq}];
        end else begin
            o_px <= mem_tx[(int'(i_tab_addr) < TAB_TOTAL) ? i_tab_addr : '0];
            o_py <= mem_ty[(int'(i_tab_addr) < TAB_TOTAL) ? i_tab_addr : '0];
        end
    end
endmodule

[rtl/cnd_div.sv]
// ----------------------------------------------------------------------------
// cnd_div
// restoring divider for the confidence ratio, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cnd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    import cnd_pkg::*;

    // numerator is (num << 16), quotient capped at 16 bits since num <= den
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [16:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;

    assign w_trial = {r_rem[31:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd17;
                r_rem  <= {1'b0, i_num};
                r_den  <= (i_den == 32'd0) ? 32'd1 : i_den;
                r_q    <= '0;
            end else if (r_busy) begin
                // first step compares num itself, then 16 shifted steps
                if (r_cnt == 5'd17) begin
                    if (r_rem >= {1'b0, r_den}) begin
                        r_rem <= r_rem - {1'b0, r_den};
                        r_q   <= 17'd1;
                    end
                end else if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = (r_q[16]) ? 16'hFFFF : r_q[15:0];
endmodule

[rtl/cnd_search.sv]
// ----------------------------------------------------------------------------
// cnd_search
// walks the constellation points, keeps nearest and second nearest
// ----------------------------------------------------------------------------
module cnd_search (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2:0]             i_mod,
    input  logic                   i_profile,
    input  logic signed [cnd_pkg::SW-1:0] i_si,
    input  logic signed [cnd_pkg::SW-1:0] i_sq,
    output logic                   o_done,
    output cnd_pkg::t_search_res   o_res
);
    import cnd_pkg::*;

    logic [2:0]    r_m;
    logic          r_square;
    logic [2:0]    r_sb;
    logic [10:0]   r_count;
    logic [TAB_AW-1:0] r_base;
    logic [10:0]   r_k;       // read address counter
    logic [10:0]   r_kd;      // index of data now at rom output
    logic          r_rd_v;
    logic          r_busy;
    logic signed [SW-1:0] r_si;
    logic signed [SW-1:0] r_sq;
    logic [33:0]   r_d1;
    logic [33:0]   r_d2;
    logic [IW-1:0] r_best;
    t_coord        w_px;
    t_coord        w_py;
    logic signed [SW:0] w_dx;
    logic signed [SW:0] w_dy;
    // magnitudes stay below 2^16: sample plus the largest rom coordinate
    logic [SW-1:0]   w_ax;
    logic [SW-1:0]   w_ay;
    logic [2*SW-1:0] w_sx;
    logic [2*SW-1:0] w_sy;
    logic [33:0]   w_d;
    logic [2:0]    w_m;
    logic [3:0]    w_bits;

    always_comb begin
        w_m = (i_mod > MOD_1024QAM) ? MOD_QPSK : i_mod;
        case (w_m)
            MOD_QPSK:   w_bits = 4'd2;
            MOD_8PSK:   w_bits = 4'd3;
            MOD_16QAM:  w_bits = 4'd4;
            MOD_64QAM:  w_bits = 4'd6;
            MOD_256QAM: w_bits = 4'd8;
            default:    w_bits = 4'd10;
        endcase
    end

    cnd_rom u_rom (
        .i_clk      (i_clk),
        .i_square   (r_square),
        .i_row      (2'(r_sb - 3'd2)),
        .i_sb       (r_sb),
        .i_k        (r_k[IW-1:0]),
        .i_tab_addr (TAB_AW'(r_base + TAB_AW'(r_k))),
        .o_px       (w_px),
        .o_py       (w_py)
    );

    always_comb begin
        w_dx = (SW+1)'(r_si) - (SW+1)'(w_px);
        w_dy = (SW+1)'(r_sq) - (SW+1)'(w_py);
        w_ax = SW'(w_dx[SW] ? -w_dx : w_dx);
        w_ay = SW'(w_dy[SW] ? -w_dy : w_dy);
        w_sx = (2*SW)'(w_ax) * (2*SW)'(w_ax);
        w_sy = (2*SW)'(w_ay) * (2*SW)'(w_ay);
        w_d  = 34'(w_sx) + 34'(w_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_m      <= w_m;
                r_square <= (w_m == MOD_1024QAM) || (w_m >= MOD_16QAM && i_profile);
                r_sb     <= 3'(w_bits >> 1);
                r_count  <= 11'(1) << w_bits;
                case (w_m)
                    MOD_QPSK:  r_base <= TAB_AW'(0);
                    MOD_8PSK:  r_base <= TAB_AW'(4);
                    MOD_16QAM: r_base <= TAB_AW'(12);
                    MOD_64QAM: r_base <= TAB_AW'(28);
                    default:   r_base <= TAB_AW'(92);
                endcase
                r_si   <= i_si;
                r_sq   <= i_sq;
                r_k    <= '0;
                r_busy <= 1'b1;
                r_rd_v <= 1'b0;
                r_d1   <= '1;
                r_d2   <= '1;
                r_best <= '0;
            end else if (r_busy) begin
                r_rd_v <= (r_k < r_count);
                r_kd   <= r_k;
                if (r_k < r_count) begin
                    r_k <= r_k + 11'd1;
                end
                if (r_rd_v) begin
                    if (w_d < r_d1) begin
                        r_d2   <= r_d1;
                        r_d1   <= w_d;
                        r_best <= r_kd[IW-1:0];
                    end else if (w_d < r_d2) begin
                        r_d2 <= w_d;
                    end
                end
                if (r_rd_v && r_kd == r_count - 11'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    logic [IW-1:0] w_sym;
    always_comb begin
        case (r_m)
            MOD_QPSK: begin
                case (r_best[1:0])
                    2'd0:    w_sym = IW'(0);
                    2'd1:    w_sym = IW'(3);
                    2'd2:    w_sym = IW'(1);
                    default: w_sym = IW'(2);
                endcase
            end
            MOD_8PSK: begin
                case (r_best[2:0])
                    3'd0:    w_sym = IW'(1);
                    3'd1:    w_sym = IW'(0);
                    3'd2:    w_sym = IW'(2);
                    3'd3:    w_sym = IW'(3);
                    3'd4:    w_sym = IW'(7);
                    3'd5:    w_sym = IW'(6);
                    3'd6:    w_sym = IW'(4);
                    default: w_sym = IW'(5);
                endcase
            end
            default: w_sym = r_best;
        endcase
        o_res.symbol  = w_sym;
        o_res.nearest = (r_d1[33:32] != 2'd0) ? 32'hFFFF_FFFF : r_d1[31:0];
        o_res.next    = (r_d2[33:32] != 2'd0) ? 32'hFFFF_FFFF : r_d2[31:0];
    end
endmodule

[rtl/constellation_nearest_demapper.sv]
// ----------------------------------------------------------------------------
// constellation_nearest_demapper
// hard decision qam/psk demapper with nearest and next distance and confidence
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one i/q sample item (q3.12) on i_valid/o_ready
//   output channel carries symbol, both squared distances (q8.24, saturated)
//   and confidence (q0.16) on o_valid/i_ready
//   apb port: modulation at 0x0, profile at 0x4, write only while idle
//   an item passes through the point walk (one rom read per cycle, rom
//   output registered) and then the serial divide; one item is in
//   flight at a time
//   a held result sits in the output register; once taken the next item
//   is accepted, so a stalled receiver simply holds the block
//   reset clears both registers to zero (qpsk, tabled profile) and all
//   handshake state; the rom needs no clearing
// ----------------------------------------------------------------------------
module constellation_nearest_demapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sample_i,
    input  logic [15:0] i_sample_q,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_symbol,
    output logic [31:0] o_nearest_distance,
    output logic [31:0] o_next_distance,
    output logic [15:0] o_confidence,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cnd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_DIV, S_OUT} t_state;

    t_state      r_state;
    logic [2:0]  r_mod;
    logic        r_profile;
    t_search_res r_res;
    logic        w_acc;
    logic        w_s_done;
    t_search_res w_s_res;
    logic        w_d_done;
    logic [15:0] w_quot;
    logic        w_wr;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite;
    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign o_valid = (r_state == S_OUT);

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= MOD_QPSK;
            r_profile <= 1'b0;
        end else if (w_wr) begin
            if (paddr[2] == REG_MODULATION) begin
                r_mod <= pwdata[2:0];
            end else begin
                r_profile <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_PROFILE) begin
            prdata = {31'd0, r_profile};
        end else begin
            prdata = {29'd0, r_mod};
        end
    end

    cnd_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc),
        .i_mod     (r_mod),
        .i_profile (r_profile),
        .i_si      (i_sample_i),
        .i_sq      (i_sample_q),
        .o_done    (w_s_done),
        .o_res     (w_s_res)
    );

    // confidence = (next - nearest) / next
    cnd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_s_done),
        .i_num   (w_s_res.next - w_s_res.nearest),
        .i_den   (w_s_res.next),
        .o_done  (w_d_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (w_acc) r_state <= S_SEARCH;
                S_SEARCH: if (w_s_done) begin
                    r_state <= S_DIV;
                    r_res   <= w_s_res;
                end
                S_DIV: if (w_d_done) begin
                    r_state      <= S_OUT;
                    o_confidence <= w_quot;
                end
                S_OUT:    if (i_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_symbol           = r_res.symbol;
    assign o_nearest_distance = r_res.nearest;
    assign o_next_distance    = r_res.next;

    // nearest never exceeds next on a delivered item
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nearest_distance <= o_next_distance))
        else $error("nearest above next");
    // search finishes only while searching
    a_sdone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_done |-> (r_state == S_SEARCH))
        else $error("stray search done");
    // divider finishes only in divide state
    a_ddone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_done |-> (r_state == S_DIV))
        else $error("stray divide done");
endmodule
